[rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/smk_pkg.sv]
package smk_pkg;

	localparam int K_MAX   = 16;
	localparam int CNT_W   = $clog2(K_MAX + 1);
	localparam int DATA_W  = 32;
	localparam int K_W     = 5;
	localparam int CMP_W   = (K_W > CNT_W) ? K_W : CNT_W;
	localparam int ADDR_W  = 3;
	localparam int PDATA_W = 32;

	localparam logic [ADDR_W-1:0] REG_SELECT_COUNT = ADDR_W'(0);
	localparam logic [K_W-1:0]    SELECT_COUNT_RST = K_W'(4);

	typedef enum logic {
		ST_COLLECT,
		ST_EMIT
	} state_t;

	// per-cycle command broadcast along the cell row
	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

[rtl/smk_in_if.sv]
interface smk_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [smk_pkg::DATA_W-1:0]  sample_value;
	logic                               set_end;

	modport source (output valid, output sample_value, output set_end, input ready);
	modport sink (input valid, input sample_value, input set_end, output ready);
endinterface

[rtl/smk_out_if.sv]
interface smk_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [smk_pkg::DATA_W-1:0]  result_value;
	logic                               result_last;
	logic                               no_answer;

	modport source (output valid, output result_value, output result_last,
		output no_answer, input ready);
	modport sink (input valid, input result_value, input result_last,
		input no_answer, output ready);
endinterface

[rtl/smk_cell.sv]
module smk_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  smk_pkg::cell_ctl_t                ctl,
	input  logic signed [smk_pkg::DATA_W-1:0] sample,
	input  logic signed [smk_pkg::DATA_W-1:0] prev_val,
	input  logic                              prev_valid,
	input  logic                              prev_take,
	input  logic signed [smk_pkg::DATA_W-1:0] next_val,
	input  logic                              next_valid,
	output logic signed [smk_pkg::DATA_W-1:0] val,
	output logic                              valid,
	output logic                              take
);

	logic signed [smk_pkg::DATA_W-1:0] val_q;
	logic                              valid_q;

	// strict compare: a new value lands after any equal ones
	assign take  = !valid_q || (sample < val_q);
	assign val   = val_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end else if (ctl.insert) begin
			valid_q <= valid_q | prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= next_val;
		end else if (ctl.insert && take) begin
			// take the neighbour's value if it moved up, else the new sample
			val_q <= prev_take ? prev_val : sample;
		end
	end

endmodule

[rtl/smk_cfg.sv]
module smk_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [smk_pkg::ADDR_W-1:0]         paddr,
	input  logic [smk_pkg::PDATA_W-1:0]        pwdata,
	output logic [smk_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready,
	output logic [smk_pkg::K_W-1:0]            select_count
);

	logic [smk_pkg::K_W-1:0] select_count_q;
	logic                    hit;

	assign hit          = (paddr == smk_pkg::REG_SELECT_COUNT);
	assign pready       = 1'b1;
	assign select_count = select_count_q;
	assign prdata       = hit ? smk_pkg::PDATA_W'(select_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_count_q <= smk_pkg::SELECT_COUNT_RST;
		end else if (psel && penable && pwrite && hit) begin
			select_count_q <= pwdata[smk_pkg::K_W-1:0];
		end
	end

endmodule

[rtl/smk_ctrl.sv]
`include "assert_macros.svh"

module smk_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [smk_pkg::K_W-1:0]           select_count,
	input  logic                              in_valid,
	input  logic                              in_set_end,
	output logic                              in_ready,
	input  logic signed [smk_pkg::DATA_W-1:0] head_val,
	output smk_pkg::cell_ctl_t                ctl,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [smk_pkg::DATA_W-1:0] out_value,
	output logic                              out_last,
	output logic                              out_no_answer
);

	smk_pkg::state_t                  state_q, state_nxt;
	logic [smk_pkg::CNT_W-1:0]        fill_q, fill_nxt, remain_q;
	logic                             na_q, na_nxt;
	logic                             in_fire, emit, ending;
	logic [smk_pkg::CMP_W-1:0]        k_cmp;

	logic                             out_valid_q, out_last_q, out_na_q;
	logic signed [smk_pkg::DATA_W-1:0] out_value_q;

	assign in_fire  = in_valid && in_ready;
	assign emit     = (state_q == smk_pkg::ST_EMIT) && (!out_valid_q || out_ready);
	assign ending   = in_fire && in_set_end;
	assign k_cmp    = smk_pkg::CMP_W'(select_count);
	assign fill_nxt = (fill_q == smk_pkg::CNT_W'(smk_pkg::K_MAX)) ?
		fill_q : fill_q + smk_pkg::CNT_W'(1);
	assign na_nxt   = (select_count == '0) ||
		(k_cmp > smk_pkg::CMP_W'(smk_pkg::K_MAX)) ||
		(k_cmp > smk_pkg::CMP_W'(fill_nxt));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			smk_pkg::ST_COLLECT: begin
				if (ending) begin
					state_nxt = smk_pkg::ST_EMIT;
				end
			end
			smk_pkg::ST_EMIT: begin
				if (emit && remain_q == smk_pkg::CNT_W'(1)) begin
					state_nxt = smk_pkg::ST_COLLECT;
				end
			end
			default: state_nxt = smk_pkg::ST_COLLECT;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		ctl.insert = 1'b0;
		ctl.shift  = 1'b0;
		ctl.clear  = 1'b0;
		case (state_q)
			smk_pkg::ST_COLLECT: begin
				in_ready   = 1'b1;
				ctl.insert = in_valid;
			end
			smk_pkg::ST_EMIT: begin
				// drop the whole row after the final beat
				ctl.clear = emit && (remain_q == smk_pkg::CNT_W'(1));
				ctl.shift = emit && !na_q && (remain_q != smk_pkg::CNT_W'(1));
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smk_pkg::ST_COLLECT;
			fill_q      <= '0;
			remain_q    <= '0;
			na_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.clear) begin
				fill_q <= '0;
			end else if (in_fire) begin
				fill_q <= fill_nxt;
			end
			if (ending) begin
				na_q     <= na_nxt;
				remain_q <= na_nxt ? smk_pkg::CNT_W'(1) : smk_pkg::CNT_W'(select_count);
			end else if (emit) begin
				remain_q <= remain_q - smk_pkg::CNT_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= na_q ? '0 : head_val;
			out_last_q  <= na_q || (remain_q == smk_pkg::CNT_W'(1));
			out_na_q    <= na_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_value     = out_value_q;
	assign out_last      = out_last_q;
	assign out_no_answer = out_na_q;

	`ASSERT_ALWAYS(a_remain_live, clk, arst_n, (state_q != smk_pkg::ST_EMIT) || (remain_q != '0), "emit phase with nothing left to send")
	`ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= smk_pkg::CNT_W'(smk_pkg::K_MAX), "fill count above row length")
	`ASSERT_ALWAYS(a_na_last, clk, arst_n, !(out_valid_q && out_na_q) || out_last_q, "no-answer beat not marked last")
	`ASSERT_NEXT(a_clear_done, clk, arst_n, ctl.clear, (state_q == smk_pkg::ST_COLLECT) && (fill_q == '0), "row clear did not return to collection")

endmodule

[rtl/smallest_k_selector_unit.sv]
// A value enters the cell row at the edge it is accepted; the set-end beat moves state_q
// to the emit state, from which the first result beat is registered into the output.
// Throughput: one input beat per cycle within a set; after set end the row unloads one
// result per cycle through the head cell while the output is not stalled (k beats, or
// one no-answer beat), input held.
// Reset (arst_n low, asynchronous): row empty, counts zero, select_count back to 4.
module smallest_k_selector_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	smk_in_if.sink                       samples,
	smk_out_if.source                    results,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [smk_pkg::ADDR_W-1:0]   paddr,
	input  logic [smk_pkg::PDATA_W-1:0]  pwdata,
	output logic [smk_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	logic [smk_pkg::K_W-1:0]           select_count;
	smk_pkg::cell_ctl_t                ctl;
	logic signed [smk_pkg::DATA_W-1:0] cell_val [smk_pkg::K_MAX];
	logic                              cell_valid [smk_pkg::K_MAX];
	logic                              cell_take [smk_pkg::K_MAX];

	smk_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.select_count (select_count)
	);

	smk_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.select_count  (select_count),
		.in_valid      (samples.valid),
		.in_set_end    (samples.set_end),
		.in_ready      (samples.ready),
		.head_val      (cell_val[0]),
		.ctl           (ctl),
		.out_valid     (results.valid),
		.out_ready     (results.ready),
		.out_value     (results.result_value),
		.out_last      (results.result_last),
		.out_no_answer (results.no_answer)
	);

	for (genvar i = 0; i < smk_pkg::K_MAX; i++) begin : g_cell
		logic signed [smk_pkg::DATA_W-1:0] p_val, n_val;
		logic                              p_valid, p_take, n_valid;

		if (i == 0) begin : g_head
			assign p_val   = '0;
			assign p_valid = 1'b1;
			assign p_take  = 1'b0;
		end else begin : g_body
			assign p_val   = cell_val[i-1];
			assign p_valid = cell_valid[i-1];
			assign p_take  = cell_take[i-1];
		end

		if (i == smk_pkg::K_MAX - 1) begin : g_tail
			assign n_val   = '0;
			assign n_valid = 1'b0;
		end else begin : g_inner
			assign n_val   = cell_val[i+1];
			assign n_valid = cell_valid[i+1];
		end

		smk_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.sample     (samples.sample_value),
			.prev_val   (p_val),
			.prev_valid (p_valid),
			.prev_take  (p_take),
			.next_val   (n_val),
			.next_valid (n_valid),
			.val        (cell_val[i]),
			.valid      (cell_valid[i]),
			.take       (cell_take[i])
		);
	end

endmodule
